>>> sv/keccak_f800_sponge_unit_defines.svh
// Assertion macros for the Keccak-f[800] sponge unit.
`ifndef KECCAK_F800_SPONGE_UNIT_DEFINES_SVH
`define KECCAK_F800_SPONGE_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define KFS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define KFS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/kfs_pkg.sv
// Shared types, constants and round constant table for the Keccak-f[800] sponge.
package kfs_pkg;

    localparam int WORD_W     = 32;
    localparam int LANES      = 25;
    localparam int LANE_IDX_W = 5;
    localparam int STD_ROUNDS = 22;
    localparam int WALK_LEN   = 24;

    localparam logic REQ_ABSORB = 1'b0;
    localparam logic REQ_FINISH = 1'b1;

    localparam logic [WORD_W-1:0] PAD_FIRST = 32'h0000_0001;
    localparam logic [WORD_W-1:0] PAD_LAST  = 32'h8000_0000;

    localparam logic [LANE_IDX_W-1:0] LAST_LANE_IDX = 5'(LANES - 1);

    // rho/pi walk: destination lane and rotation, starting from lane 1
    localparam logic [LANE_IDX_W-1:0] WALK_LANE [WALK_LEN] = '{
        5'd10, 5'd7,  5'd11, 5'd17, 5'd18, 5'd3,  5'd5,  5'd16,
        5'd8,  5'd21, 5'd24, 5'd4,  5'd15, 5'd23, 5'd19, 5'd13,
        5'd12, 5'd2,  5'd20, 5'd14, 5'd22, 5'd9,  5'd6,  5'd1
    };
    localparam logic [4:0] WALK_ROT [WALK_LEN] = '{
        5'd1,  5'd3,  5'd6,  5'd10, 5'd15, 5'd21, 5'd28, 5'd4,
        5'd13, 5'd23, 5'd2,  5'd14, 5'd27, 5'd9,  5'd24, 5'd8,
        5'd25, 5'd11, 5'd30, 5'd18, 5'd7,  5'd29, 5'd20, 5'd12
    };

    typedef logic [LANES-1:0][WORD_W-1:0] lanes_t;

    typedef struct packed {
        logic              req_type;
        logic [WORD_W-1:0] data_word;
    } req_t;

    typedef struct packed {
        logic [WORD_W-1:0]     state_word;
        logic [LANE_IDX_W-1:0] lane_index;
        logic                  last_lane;
    } lane_t;

    function automatic logic [WORD_W-1:0] rotl32(input logic [WORD_W-1:0] x,
                                                 input logic [4:0] n);
        logic [2*WORD_W-1:0] t;
        t = {x, x} << n;
        return t[2*WORD_W-1:WORD_W];
    endfunction

    function automatic logic [WORD_W-1:0] round_const(input logic [4:0] idx);
        logic [WORD_W-1:0] rc;
        case (idx)
            5'd0:    rc = 32'h0000_0001;
            5'd1:    rc = 32'h0000_8082;
            5'd2:    rc = 32'h0000_808a;
            5'd3:    rc = 32'h8000_8000;
            5'd4:    rc = 32'h0000_808b;
            5'd5:    rc = 32'h8000_0001;
            5'd6:    rc = 32'h8000_8081;
            5'd7:    rc = 32'h0000_8009;
            5'd8:    rc = 32'h0000_008a;
            5'd9:    rc = 32'h0000_0088;
            5'd10:   rc = 32'h8000_8009;
            5'd11:   rc = 32'h8000_000a;
            5'd12:   rc = 32'h8000_808b;
            5'd13:   rc = 32'h0000_008b;
            5'd14:   rc = 32'h0000_8089;
            5'd15:   rc = 32'h0000_8003;
            5'd16:   rc = 32'h0000_8002;
            5'd17:   rc = 32'h0000_0080;
            5'd18:   rc = 32'h0000_800a;
            5'd19:   rc = 32'h8000_000a;
            5'd20:   rc = 32'h8000_8081;
            5'd21:   rc = 32'h0000_8080;
            default: rc = '0;
        endcase
        return rc;
    endfunction

endpackage

>>> sv/kfs_round.sv
// One Keccak-f[800] round: theta, rho, pi, chi and iota.
module kfs_round (
    input  kfs_pkg::lanes_t                  lanes_in,
    input  logic [kfs_pkg::WORD_W-1:0]       rc,
    output kfs_pkg::lanes_t                  lanes_out
);

    logic [4:0][kfs_pkg::WORD_W-1:0] col;
    logic [4:0][kfs_pkg::WORD_W-1:0] dcol;
    kfs_pkg::lanes_t                 th;
    kfs_pkg::lanes_t                 pi_src;
    kfs_pkg::lanes_t                 rp;
    kfs_pkg::lanes_t                 chi;

    always_comb
    begin
        for (int x = 0; x < 5; x++)
        begin
            col[x] = lanes_in[x] ^ lanes_in[x + 5] ^ lanes_in[x + 10] ^
                     lanes_in[x + 15] ^ lanes_in[x + 20];
        end
        for (int x = 0; x < 5; x++)
        begin
            dcol[x] = col[(x + 4) % 5] ^ kfs_pkg::rotl32(col[(x + 1) % 5], 5'd1);
        end
        for (int i = 0; i < kfs_pkg::LANES; i++)
        begin
            th[i] = lanes_in[i] ^ dcol[i % 5];
        end
    end

    always_comb
    begin
        pi_src = '0;
        rp     = '0;
        pi_src[0] = th[1];
        for (int i = 1; i < kfs_pkg::WALK_LEN; i++)
        begin
            pi_src[i] = th[kfs_pkg::WALK_LANE[i - 1]];
        end
        rp[0] = th[0];
        for (int i = 0; i < kfs_pkg::WALK_LEN; i++)
        begin
            rp[kfs_pkg::WALK_LANE[i]] = kfs_pkg::rotl32(pi_src[i], kfs_pkg::WALK_ROT[i]);
        end
    end

    always_comb
    begin
        for (int y = 0; y < kfs_pkg::LANES; y += 5)
        begin
            for (int x = 0; x < 5; x++)
            begin
                chi[y + x] = rp[y + x] ^ (~rp[y + (x + 1) % 5] & rp[y + (x + 2) % 5]);
            end
        end
        lanes_out    = chi;
        lanes_out[0] = chi[0] ^ rc;
    end

endmodule

>>> sv/keccak_f800_sponge_unit.sv
// Top level of the reduced-round Keccak-f[800] sponge unit.
//
// channel   dir   handshake                 beat
// req       in    req_valid / req_stall     kfs_pkg::req_t (absorb or finish)
// lane      out   lane_valid / lane_stall   kfs_pkg::lane_t (one state lane)
// cfg       in    cfg_valid / cfg_ready     cfg_data = num_rounds
//
// The word that fills the rate starts n = min(num_rounds, MAX_ROUNDS) rounds,
// one round per cycle through the shared round datapath.
// Finish pads the rate, runs the n rounds, then emits 25 lane beats; lane_stall holds them.
// req_stall is high in rounds and, after a finish, until the last lane loads.
// Reset clears all lanes, the word position, and sets num_rounds to 10.
`include "keccak_f800_sponge_unit_defines.svh"

module keccak_f800_sponge_unit #(
    parameter int RATE_WORDS = 17,
    parameter int MAX_ROUNDS = 22
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  kfs_pkg::req_t       req,
    output logic                lane_valid,
    input  logic                lane_stall,
    output kfs_pkg::lane_t      lane,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [4:0]          cfg_data
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_PERM = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    localparam int IW = kfs_pkg::LANE_IDX_W;
    localparam logic [IW-1:0] POS_LAST   = IW'(RATE_WORDS - 1);
    localparam logic [4:0]    LAST_ROUND = 5'(kfs_pkg::STD_ROUNDS - 1);

    logic [1:0]      state_reg, state_next;
    logic [IW-1:0]   pos_reg, pos_next;
    logic [4:0]      rnd_reg, rnd_next;
    logic            fin_reg, fin_next;
    logic [IW-1:0]   emit_idx_reg, emit_idx_next;
    logic [4:0]      num_rounds_reg;
    kfs_pkg::lanes_t lanes_reg, lanes_next;
    kfs_pkg::lanes_t round_out;
    logic            lane_valid_reg, lane_valid_next;
    kfs_pkg::lane_t  lane_reg;
    logic            load_lane;
    logic            req_accept;
    logic [4:0]      n_eff;
    logic [4:0]      rnd_first;

    assign req_stall  = (state_reg != ST_IDLE);
    assign req_accept = req_valid & ~req_stall;
    assign cfg_ready  = 1'b1;
    assign lane_valid = lane_valid_reg;
    assign lane       = lane_reg;

    assign n_eff     = (num_rounds_reg > 5'(MAX_ROUNDS)) ? 5'(MAX_ROUNDS) : num_rounds_reg;
    assign rnd_first = 5'(kfs_pkg::STD_ROUNDS) - n_eff;

    kfs_round u_round (
        .lanes_in  (lanes_reg),
        .rc        (kfs_pkg::round_const(rnd_reg)),
        .lanes_out (round_out)
    );

    always_comb
    begin
        state_next    = state_reg;
        pos_next      = pos_reg;
        rnd_next      = rnd_reg;
        fin_next      = fin_reg;
        emit_idx_next = emit_idx_reg;
        lanes_next    = lanes_reg;
        load_lane     = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_accept)
                begin
                    if (req.req_type == kfs_pkg::REQ_ABSORB)
                    begin
                        lanes_next[pos_reg] = req.data_word;
                        if (pos_reg == POS_LAST)
                        begin
                            pos_next = '0;
                            fin_next = 1'b0;
                            rnd_next = rnd_first;
                            if (n_eff != 5'd0)
                            begin
                                state_next = ST_PERM;
                            end
                        end
                        else
                        begin
                            pos_next = pos_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        for (int i = 0; i < RATE_WORDS; i++)
                        begin
                            if (IW'(i) >= pos_reg)
                            begin
                                lanes_next[i] = '0;
                            end
                        end
                        lanes_next[pos_reg]        = kfs_pkg::PAD_FIRST;
                        lanes_next[RATE_WORDS - 1] = lanes_next[RATE_WORDS - 1] |
                                                     kfs_pkg::PAD_LAST;
                        pos_next      = '0;
                        fin_next      = 1'b1;
                        emit_idx_next = '0;
                        rnd_next      = rnd_first;
                        state_next    = (n_eff != 5'd0) ? ST_PERM : ST_EMIT;
                    end
                end
            end
            ST_PERM:
            begin
                lanes_next = round_out;
                rnd_next   = rnd_reg + 1'b1;
                if (rnd_reg == LAST_ROUND)
                begin
                    state_next = fin_reg ? ST_EMIT : ST_IDLE;
                end
            end
            ST_EMIT:
            begin
                if (!lane_valid_reg || !lane_stall)
                begin
                    load_lane     = 1'b1;
                    emit_idx_next = emit_idx_reg + 1'b1;
                    if (emit_idx_reg == kfs_pkg::LAST_LANE_IDX)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign lane_valid_next = load_lane | (lane_valid_reg & lane_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            pos_reg        <= '0;
            rnd_reg        <= '0;
            fin_reg        <= 1'b0;
            emit_idx_reg   <= '0;
            num_rounds_reg <= 5'd10;
            lanes_reg      <= '0;
            lane_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            pos_reg        <= pos_next;
            rnd_reg        <= rnd_next;
            fin_reg        <= fin_next;
            emit_idx_reg   <= emit_idx_next;
            lanes_reg      <= lanes_next;
            lane_valid_reg <= lane_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                num_rounds_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_lane)
        begin
            lane_reg.state_word <= lanes_reg[emit_idx_reg];
            lane_reg.lane_index <= emit_idx_reg;
            lane_reg.last_lane  <= (emit_idx_reg == kfs_pkg::LAST_LANE_IDX);
        end
    end

    `KFS_ASSERT_NOW(a_pos_in_rate, 1'b1, pos_reg <= POS_LAST, "word position past rate")
    `KFS_ASSERT_NOW(a_round_range, state_reg == ST_PERM, rnd_reg <= LAST_ROUND,
                    "round index out of range")
    `KFS_ASSERT_NEXT(a_emit_done, state_reg == ST_EMIT && load_lane &&
                     emit_idx_reg == kfs_pkg::LAST_LANE_IDX,
                     state_reg == ST_IDLE && lane_valid_reg && lane_reg.last_lane,
                     "last lane did not end emit")
    `KFS_ASSERT_NEXT(a_full_rate_permutes, req_accept &&
                     req.req_type == kfs_pkg::REQ_ABSORB &&
                     pos_reg == POS_LAST && n_eff != 5'd0,
                     state_reg == ST_PERM && pos_reg == '0,
                     "full rate did not start permutation")

endmodule

>>> bench/keccak_f800_sponge_unit_tb.sv
// Self-checking testbench for keccak_f800_sponge_unit: absorb/finish traffic checked per lane.
module keccak_f800_sponge_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RATE_WORDS  = 17;
    localparam int MAX_ROUNDS  = 22;
    localparam int CYCLE_LIMIT = 200000;
    localparam int SETTLE      = 40;

    localparam logic [kfs_pkg::WORD_W-1:0] IOTA_RC [kfs_pkg::STD_ROUNDS] = '{
        32'h0000_0001, 32'h0000_8082, 32'h0000_808a, 32'h8000_8000, 32'h0000_808b,
        32'h8000_0001, 32'h8000_8081, 32'h0000_8009, 32'h0000_008a, 32'h0000_0088,
        32'h8000_8009, 32'h8000_000a, 32'h8000_808b, 32'h0000_008b, 32'h0000_8089,
        32'h0000_8003, 32'h0000_8002, 32'h0000_0080, 32'h0000_800a, 32'h8000_000a,
        32'h8000_8081, 32'h0000_8080
    };

    logic           clk = 1'b0;
    logic           rst_n = 1'b0;
    logic           req_valid = 1'b0;
    logic           req_stall;
    kfs_pkg::req_t  req = '0;
    logic           lane_valid;
    logic           lane_stall = 1'b0;
    kfs_pkg::lane_t lane;
    logic           cfg_valid = 1'b0;
    logic           cfg_ready;
    logic [4:0]     cfg_data = 5'd0;

    logic [kfs_pkg::WORD_W-1:0] sponge_lanes [kfs_pkg::LANES];
    int                         absorb_pos;
    logic [4:0]                 rounds_cfg;

    kfs_pkg::req_t  pending_reqs [$];
    kfs_pkg::lane_t lanes_due [$];

    bit idle_on;
    int gap_left;
    int stall_left;
    int mismatches;
    int lanes_seen;
    int absorbs_taken;
    int finishes_taken;
    int cfg_writes;
    int cycles;

    keccak_f800_sponge_unit #(
        .RATE_WORDS (RATE_WORDS),
        .MAX_ROUNDS (MAX_ROUNDS)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .req        (req),
        .lane_valid (lane_valid),
        .lane_stall (lane_stall),
        .lane       (lane),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    function automatic logic [kfs_pkg::WORD_W-1:0] rol32(input logic [kfs_pkg::WORD_W-1:0] x,
                                                         input int n);
        if (n == 0)
        begin
            return x;
        end
        return (x << n) | (x >> (kfs_pkg::WORD_W - n));
    endfunction

    function automatic void keccak_rounds();
        int n;
        int r;
        int i;
        int y;
        logic [kfs_pkg::WORD_W-1:0] col [5];
        logic [kfs_pkg::WORD_W-1:0] mix [5];
        logic [kfs_pkg::WORD_W-1:0] row [5];
        logic [kfs_pkg::WORD_W-1:0] carry;
        logic [kfs_pkg::WORD_W-1:0] nxt;
        n = (rounds_cfg > MAX_ROUNDS) ? MAX_ROUNDS : int'(rounds_cfg);
        for (r = kfs_pkg::STD_ROUNDS - n; r < kfs_pkg::STD_ROUNDS; r++)
        begin
            for (i = 0; i < 5; i++)
            begin
                col[i] = sponge_lanes[i] ^ sponge_lanes[i + 5] ^ sponge_lanes[i + 10]
                       ^ sponge_lanes[i + 15] ^ sponge_lanes[i + 20];
            end
            for (i = 0; i < 5; i++)
            begin
                mix[i] = col[(i + 4) % 5] ^ rol32(col[(i + 1) % 5], 1);
            end
            for (i = 0; i < kfs_pkg::LANES; i++)
            begin
                sponge_lanes[i] ^= mix[i % 5];
            end
            carry = sponge_lanes[1];
            for (i = 0; i < kfs_pkg::WALK_LEN; i++)
            begin
                nxt = sponge_lanes[kfs_pkg::WALK_LANE[i]];
                sponge_lanes[kfs_pkg::WALK_LANE[i]] = rol32(carry, int'(kfs_pkg::WALK_ROT[i]));
                carry = nxt;
            end
            for (y = 0; y < kfs_pkg::LANES; y += 5)
            begin
                for (i = 0; i < 5; i++)
                begin
                    row[i] = sponge_lanes[y + i];
                end
                for (i = 0; i < 5; i++)
                begin
                    sponge_lanes[y + i] = row[i] ^ (~row[(i + 1) % 5] & row[(i + 2) % 5]);
                end
            end
            sponge_lanes[0] ^= IOTA_RC[r];
        end
    endfunction

    function automatic void take_req(input kfs_pkg::req_t r);
        int             i;
        kfs_pkg::lane_t want;
        if (r.req_type == kfs_pkg::REQ_ABSORB)
        begin
            absorb_pos = (absorb_pos >= RATE_WORDS) ? 0 : absorb_pos;
            sponge_lanes[absorb_pos] = r.data_word;
            absorb_pos++;
            if (absorb_pos >= RATE_WORDS)
            begin
                keccak_rounds();
                absorb_pos = 0;
            end
            absorbs_taken++;
        end
        else
        begin
            for (i = absorb_pos; i < RATE_WORDS; i++)
            begin
                sponge_lanes[i] = '0;
            end
            sponge_lanes[absorb_pos] = kfs_pkg::PAD_FIRST;
            sponge_lanes[RATE_WORDS-1] |= kfs_pkg::PAD_LAST;
            keccak_rounds();
            absorb_pos = 0;
            for (i = 0; i < kfs_pkg::LANES; i++)
            begin
                want.state_word = sponge_lanes[i];
                want.lane_index = kfs_pkg::LANE_IDX_W'(i);
                want.last_lane  = (i == kfs_pkg::LANES - 1);
                lanes_due.push_back(want);
            end
            finishes_taken++;
        end
    endfunction

    task automatic report_mismatch(input string what);
        mismatches++;
        $display("MISMATCH at cycle %0d: %s", cycles, what);
    endtask

    task automatic check_lane(input kfs_pkg::lane_t got);
        kfs_pkg::lane_t want;
        lanes_seen++;
        if (lanes_due.size() == 0)
        begin
            report_mismatch($sformatf("unexpected lane beat, index %0d", got.lane_index));
            return;
        end
        want = lanes_due.pop_front();
        if (got.state_word !== want.state_word)
        begin
            report_mismatch($sformatf("lane %0d word %h, want %h",
                                      want.lane_index, got.state_word, want.state_word));
        end
        if (got.lane_index !== want.lane_index)
        begin
            report_mismatch($sformatf("lane index %0d, want %0d",
                                      got.lane_index, want.lane_index));
        end
        if (got.last_lane !== want.last_lane)
        begin
            report_mismatch($sformatf("lane %0d last flag %b, want %b",
                                      want.lane_index, got.last_lane, want.last_lane));
        end
    endtask

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req       <= '0;
            gap_left  = 0;
        end
        else if (!(req_valid && req_stall))
        begin
            if (req_valid)
            begin
                take_req(req);
                void'(pending_reqs.pop_front());
            end
            if (gap_left > 0)
            begin
                gap_left--;
                req_valid <= 1'b0;
            end
            else if (pending_reqs.size() > 0)
            begin
                if (idle_on && $urandom_range(0, 4) == 0)
                begin
                    gap_left = $urandom_range(0, 2);
                    req_valid <= 1'b0;
                end
                else
                begin
                    req_valid <= 1'b1;
                    req       <= pending_reqs[0];
                end
            end
            else
            begin
                req_valid <= 1'b0;
            end
        end
    end

    // lane monitor and stall source
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lane_stall <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (lane_valid && !lane_stall)
            begin
                check_lane(lane);
            end
            if (stall_left > 0)
            begin
                stall_left--;
                lane_stall <= 1'b1;
            end
            else if (idle_on && $urandom_range(0, 4) == 0)
            begin
                stall_left = $urandom_range(0, 2);
                lane_stall <= 1'b1;
            end
            else
            begin
                lane_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d lanes outstanding",
                     cycles, lanes_due.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic set_rounds(input logic [4:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        rounds_cfg = value;
        cfg_writes++;
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        while (pending_reqs.size() > 0 || req_valid || lanes_due.size() > 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE) @(posedge clk);
    endtask

    function automatic void push_absorb(input logic [kfs_pkg::WORD_W-1:0] word);
        kfs_pkg::req_t r;
        r.req_type  = kfs_pkg::REQ_ABSORB;
        r.data_word = word;
        pending_reqs.push_back(r);
    endfunction

    function automatic void push_finish();
        kfs_pkg::req_t r;
        r.req_type  = kfs_pkg::REQ_FINISH;
        r.data_word = $urandom();
        pending_reqs.push_back(r);
    endfunction

    function automatic logic [kfs_pkg::WORD_W-1:0] pick_word();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return $urandom();
        endcase
    endfunction

    // random messages until at least n items are queued
    function automatic void push_messages(input int n);
        int queued;
        int len;
        int k;
        queued = 0;
        while (queued < n)
        begin
            case ($urandom_range(0, 3))
                0:       len = $urandom_range(0, 4);
                1:       len = $urandom_range(16, 17);
                2:       len = $urandom_range(5, 20);
                default: len = $urandom_range(18, 35);
            endcase
            for (k = 0; k < len; k++)
            begin
                push_absorb(pick_word());
            end
            if ($urandom_range(0, 7) != 0)
            begin
                push_finish();
                queued++;
            end
            queued += len;
        end
    endfunction

    initial
    begin
        int k;
        for (k = 0; k < kfs_pkg::LANES; k++)
        begin
            sponge_lanes[k] = '0;
        end
        absorb_pos = 0;
        rounds_cfg = 5'd10;
        idle_on    = 1'b1;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // empty message at the reset round count
        push_finish();
        drain();

        // zero rounds: identity permutation exposes the padded lanes
        set_rounds(5'd0);
        push_absorb('1);
        push_absorb('0);
        push_absorb(32'ha5a5_a5a5);
        push_finish();
        drain();

        // round count above the maximum, pad lands on the last rate word
        set_rounds(5'd31);
        for (k = 0; k < RATE_WORDS - 1; k++)
        begin
            push_absorb((k % 2 == 0) ? 32'hffff_ffff : 32'h8000_0001);
        end
        push_finish();
        drain();

        set_rounds(5'd1);
        push_finish();
        push_messages(12);
        drain();

        set_rounds(5'd22);
        push_messages(12);
        drain();

        set_rounds(5'($urandom_range(0, 31)));
        push_messages(12);
        drain();

        idle_on = 1'b0;
        set_rounds(5'd10);
        push_messages(14);
        drain();

        if (lanes_due.size() != 0)
        begin
            report_mismatch($sformatf("%0d lanes never arrived", lanes_due.size()));
        end
        $display("covered %0d absorb and %0d finish beats, %0d lanes checked, %0d round settings",
                 absorbs_taken, finishes_taken, lanes_seen, cfg_writes);
        if (mismatches == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("%0d mismatches", mismatches);
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule

>>> filelist.f
+incdir+sv
sv/kfs_pkg.sv
sv/kfs_round.sv
sv/keccak_f800_sponge_unit.sv
bench/keccak_f800_sponge_unit_tb.sv
